### sv/lpt_pkg.sv
// ============================================================================
// lpt_pkg: shared definitions for the logic program tokenizer
// Token kind codes, character constants, default widths and character-class
// helper functions.
// ============================================================================
`default_nettype none

package lpt_pkg;

    // Default field widths.
    localparam int LPT_VALUE_BITS  = 32;
    localparam int LPT_LENGTH_BITS = 8;
    localparam int LPT_LINE_BITS   = 16;

    typedef logic [3:0] kind_t;
    typedef logic [7:0] char_t;

    // Token kinds as they appear on the output word.
    localparam kind_t K_EOF      = 4'd0;
    localparam kind_t K_COMMA    = 4'd1;
    localparam kind_t K_LPAREN   = 4'd2;
    localparam kind_t K_RPAREN   = 4'd3;
    localparam kind_t K_LSQUARE  = 4'd4;
    localparam kind_t K_RSQUARE  = 4'd5;
    localparam kind_t K_DOT      = 4'd6;
    localparam kind_t K_COLON    = 4'd7;
    localparam kind_t K_IMPLIED  = 4'd8;
    localparam kind_t K_QUESTION = 4'd9;
    localparam kind_t K_AND      = 4'd10;
    localparam kind_t K_NOT      = 4'd11;
    localparam kind_t K_NUMERAL  = 4'd12;
    localparam kind_t K_LOWER    = 4'd13;
    localparam kind_t K_UPPER    = 4'd14;
    localparam kind_t K_ERROR    = 4'd15;

    // Characters with a meaning of their own.
    localparam char_t CH_NL     = 8'h0A;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_LBRACE = 8'h7B;
    localparam char_t CH_RBRACE = 8'h7D;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_LSQ    = 8'h5B;
    localparam char_t CH_RSQ    = 8'h5D;
    localparam char_t CH_DOT    = 8'h2E;
    localparam char_t CH_QUEST  = 8'h3F;
    localparam char_t CH_AMP    = 8'h26;
    localparam char_t CH_COLON  = 8'h3A;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_LESS   = 8'h3C;
    localparam char_t CH_EQUAL  = 8'h3D;
    localparam char_t CH_A      = 8'h61;
    localparam char_t CH_N      = 8'h6E;
    localparam char_t CH_D      = 8'h64;
    localparam char_t CH_O      = 8'h6F;
    localparam char_t CH_T      = 8'h74;

    function automatic logic is_digit(input char_t c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower(input char_t c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_upper(input char_t c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(input char_t c);
        return is_digit(c) || is_lower(c) || is_upper(c);
    endfunction

endpackage

`default_nettype wire

### sv/lpt_if.sv
// ============================================================================
// lpt_if: handshake channels of the logic program tokenizer
// One channel for source characters and one for tokens, each with valid,
// ready and its payload.
// ============================================================================
`default_nettype none

interface lpt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, char_code, end_of_text, input ready);
    modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface lpt_token_if #(
    parameter int VALUE_BITS  = lpt_pkg::LPT_VALUE_BITS,
    parameter int LENGTH_BITS = lpt_pkg::LPT_LENGTH_BITS,
    parameter int LINE_BITS   = lpt_pkg::LPT_LINE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [3:0]             token_kind;
    logic [VALUE_BITS-1:0]  token_value;
    logic [LENGTH_BITS-1:0] word_length;
    logic [LINE_BITS-1:0]   line_number;
    logic                   last_token;

    modport source (output valid, token_kind, token_value, word_length, line_number,
                    last_token, input ready);
    modport sink   (input valid, token_kind, token_value, word_length, line_number,
                    last_token, output ready);
endinterface

`default_nettype wire

### sv/lpt_scan.sv
// ============================================================================
// lpt_scan: scanner state and token decision
// Holds the lexer state and works out, for the character on the input, the
// zero, one or two tokens it releases and the state after it.
// ============================================================================
`default_nettype none

module lpt_scan #(
    parameter int VALUE_BITS  = lpt_pkg::LPT_VALUE_BITS,
    parameter int LENGTH_BITS = lpt_pkg::LPT_LENGTH_BITS,
    parameter int LINE_BITS   = lpt_pkg::LPT_LINE_BITS,
    localparam int TOK_W      = 4 + VALUE_BITS + LENGTH_BITS + LINE_BITS + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       char_code,
    input  wire logic             end_of_text,
    output logic      [TOK_W-1:0] tok0,
    output logic      [TOK_W-1:0] tok1,
    output logic      [1:0]       tok_count
);

    // Lexer modes.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_COLON   = 3'd2;
    localparam logic [2:0] MODE_LESS    = 3'd3;
    localparam logic [2:0] MODE_NUMBER  = 3'd4;
    localparam logic [2:0] MODE_WORD    = 3'd5;
    localparam logic [2:0] MODE_PREFIX  = 3'd6;

    // Keyword prefix progress.
    localparam logic [2:0] KP_NONE = 3'd0;
    localparam logic [2:0] KP_A    = 3'd1;
    localparam logic [2:0] KP_AN   = 3'd2;
    localparam logic [2:0] KP_N    = 3'd3;
    localparam logic [2:0] KP_NO   = 3'd4;

    localparam int WIDE_W = VALUE_BITS + 4;
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

    logic [2:0]             mode_reg,  mode_next;
    logic [2:0]             kp_reg,    kp_next;
    logic [VALUE_BITS-1:0]  acc_reg,   acc_next;
    logic [LENGTH_BITS-1:0] cnt_reg,   cnt_next;
    logic                   lower_reg, lower_next;
    logic [LINE_BITS-1:0]   line_reg,  line_next;

    // Character seen from the idle mode.
    logic [2:0]             st_mode;
    logic [2:0]             st_kp;
    logic [VALUE_BITS-1:0]  st_acc;
    logic [LENGTH_BITS-1:0] st_cnt;
    logic                   st_lower;
    logic                   st_emit;
    lpt_pkg::kind_t         st_kind;
    logic                   st_line_inc;

    // Token left pending by the current mode.
    logic                   pend_valid;
    lpt_pkg::kind_t         pend_kind;
    logic [VALUE_BITS-1:0]  pend_value;
    logic [LENGTH_BITS-1:0] pend_len;

    // Numeral accumulation and word growth.
    logic [WIDE_W-1:0]      acc_wide;
    logic [VALUE_BITS-1:0]  acc_sat;
    logic [LENGTH_BITS-1:0] cnt_grow;

    logic                   a_valid;
    logic                   b_valid;
    lpt_pkg::kind_t         b_kind;
    logic                   b_last;
    logic                   use_start;
    logic                   line_inc;
    logic [TOK_W-1:0]       tok_a;
    logic [TOK_W-1:0]       tok_b;

    // Times ten plus digit, sticking at the top value on overflow.
    always_comb
    begin
        acc_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                 + WIDE_W'(char_code[3:0]);
        if (acc_wide[WIDE_W-1 -: 4] != 4'b0)
        begin
            acc_sat = '1;
        end
        else
        begin
            acc_sat = acc_wide[VALUE_BITS-1:0];
        end
        cnt_grow = (cnt_reg == '1) ? cnt_reg : cnt_reg + LENGTH_BITS'(1);
    end

    // Scanning a character from the idle mode.
    always_comb
    begin
        st_mode     = MODE_IDLE;
        st_kp       = KP_NONE;
        st_acc      = '0;
        st_cnt      = '0;
        st_lower    = 1'b0;
        st_emit     = 1'b0;
        st_kind     = lpt_pkg::K_ERROR;
        st_line_inc = 1'b0;
        priority if (char_code == lpt_pkg::CH_NL)
        begin
            st_line_inc = 1'b1;
        end
        else if (char_code == lpt_pkg::CH_SPACE || char_code == lpt_pkg::CH_TAB)
        begin
            st_mode = MODE_IDLE;
        end
        else if (char_code == lpt_pkg::CH_LBRACE)
        begin
            st_mode = MODE_COMMENT;
        end
        else if (char_code == lpt_pkg::CH_COMMA)
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_COMMA;
        end
        else if (char_code == lpt_pkg::CH_LPAREN)
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_LPAREN;
        end
        else if (char_code == lpt_pkg::CH_RPAREN)
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_RPAREN;
        end
        else if (char_code == lpt_pkg::CH_LSQ)
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_LSQUARE;
        end
        else if (char_code == lpt_pkg::CH_RSQ)
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_RSQUARE;
        end
        else if (char_code == lpt_pkg::CH_DOT)
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_DOT;
        end
        else if (char_code == lpt_pkg::CH_QUEST)
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_QUESTION;
        end
        else if (char_code == lpt_pkg::CH_AMP)
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_AND;
        end
        else if (char_code == lpt_pkg::CH_COLON)
        begin
            st_mode = MODE_COLON;
        end
        else if (char_code == lpt_pkg::CH_LESS)
        begin
            st_mode = MODE_LESS;
        end
        else if (lpt_pkg::is_digit(char_code))
        begin
            st_mode = MODE_NUMBER;
            st_acc  = VALUE_BITS'(char_code[3:0]);
        end
        else if (char_code == lpt_pkg::CH_A || char_code == lpt_pkg::CH_N)
        begin
            st_mode  = MODE_PREFIX;
            st_kp    = (char_code == lpt_pkg::CH_A) ? KP_A : KP_N;
            st_cnt   = LENGTH_BITS'(1);
            st_lower = 1'b1;
        end
        else if (lpt_pkg::is_lower(char_code) || lpt_pkg::is_upper(char_code))
        begin
            st_mode  = MODE_WORD;
            st_cnt   = LENGTH_BITS'(1);
            st_lower = lpt_pkg::is_lower(char_code);
        end
        else
        begin
            st_emit = 1'b1;
            st_kind = lpt_pkg::K_ERROR;
        end
    end

    // The token that ending the current mode would release.
    always_comb
    begin
        pend_valid = 1'b0;
        pend_kind  = lpt_pkg::K_ERROR;
        pend_value = '0;
        pend_len   = '0;
        unique case (mode_reg)
            MODE_COLON:
            begin
                pend_valid = 1'b1;
                pend_kind  = lpt_pkg::K_COLON;
            end
            MODE_LESS:
            begin
                pend_valid = 1'b1;
                pend_kind  = lpt_pkg::K_ERROR;
            end
            MODE_NUMBER:
            begin
                pend_valid = 1'b1;
                pend_kind  = lpt_pkg::K_NUMERAL;
                pend_value = acc_reg;
            end
            MODE_WORD, MODE_PREFIX:
            begin
                pend_valid = 1'b1;
                pend_kind  = lower_reg ? lpt_pkg::K_LOWER : lpt_pkg::K_UPPER;
                pend_len   = cnt_reg;
            end
            default:
            begin
                pend_valid = 1'b0;
            end
        endcase
    end

    // Next state and released tokens. Token A is a pending token that the
    // character closes; token B is whatever the character itself gives.
    always_comb
    begin
        mode_next  = mode_reg;
        kp_next    = kp_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        lower_next = lower_reg;
        line_next  = line_reg;
        a_valid    = 1'b0;
        b_valid    = 1'b0;
        b_kind     = lpt_pkg::K_EOF;
        b_last     = 1'b0;
        use_start  = 1'b0;
        line_inc   = 1'b0;

        if (end_of_text)
        begin
            a_valid    = pend_valid;
            b_valid    = 1'b1;
            b_kind     = lpt_pkg::K_EOF;
            b_last     = 1'b1;
            mode_next  = MODE_IDLE;
            kp_next    = KP_NONE;
            acc_next   = '0;
            cnt_next   = '0;
            lower_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    if (char_code == lpt_pkg::CH_RBRACE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (char_code == lpt_pkg::CH_NL)
                    begin
                        line_inc = 1'b1;
                    end
                end
                MODE_COLON:
                begin
                    if (char_code == lpt_pkg::CH_MINUS)
                    begin
                        b_valid   = 1'b1;
                        b_kind    = lpt_pkg::K_IMPLIED;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        use_start = 1'b1;
                    end
                end
                MODE_LESS:
                begin
                    if (char_code == lpt_pkg::CH_EQUAL)
                    begin
                        b_valid   = 1'b1;
                        b_kind    = lpt_pkg::K_IMPLIED;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        use_start = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (lpt_pkg::is_digit(char_code))
                    begin
                        acc_next = acc_sat;
                    end
                    else
                    begin
                        use_start = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (lpt_pkg::is_alnum(char_code))
                    begin
                        cnt_next = cnt_grow;
                    end
                    else
                    begin
                        use_start = 1'b1;
                    end
                end
                MODE_PREFIX:
                begin
                    if ((kp_reg == KP_A && char_code == lpt_pkg::CH_N)
                        || (kp_reg == KP_N && char_code == lpt_pkg::CH_O))
                    begin
                        kp_next  = kp_reg + 3'd1;
                        cnt_next = cnt_grow;
                    end
                    else if ((kp_reg == KP_AN && char_code == lpt_pkg::CH_D)
                             || (kp_reg == KP_NO && char_code == lpt_pkg::CH_T))
                    begin
                        b_valid    = 1'b1;
                        b_kind     = (kp_reg == KP_AN) ? lpt_pkg::K_AND : lpt_pkg::K_NOT;
                        mode_next  = MODE_IDLE;
                        kp_next    = KP_NONE;
                        cnt_next   = '0;
                        lower_next = 1'b0;
                    end
                    else if (lpt_pkg::is_alnum(char_code))
                    begin
                        mode_next = MODE_WORD;
                        kp_next   = KP_NONE;
                        cnt_next  = cnt_grow;
                    end
                    else
                    begin
                        use_start = 1'b1;
                    end
                end
                default:
                begin
                    use_start = 1'b1;
                end
            endcase

            if (use_start)
            begin
                a_valid    = pend_valid;
                mode_next  = st_mode;
                kp_next    = st_kp;
                acc_next   = st_acc;
                cnt_next   = st_cnt;
                lower_next = st_lower;
                b_valid    = st_emit;
                b_kind     = st_kind;
                line_inc   = st_line_inc;
            end
        end

        if (end_of_text)
        begin
            line_next = LINE_FIRST;
        end
        else if (line_inc && line_reg != '1)
        begin
            line_next = line_reg + LINE_BITS'(1);
        end
    end

    // Both tokens carry the line on which they ended.
    assign tok_a = {pend_kind, pend_value, pend_len, line_reg, 1'b0};
    assign tok_b = {b_kind, {VALUE_BITS{1'b0}}, {LENGTH_BITS{1'b0}}, line_reg, b_last};

    assign tok0      = a_valid ? tok_a : tok_b;
    assign tok1      = tok_b;
    assign tok_count = {a_valid & b_valid, a_valid ^ b_valid};

    // State registers move on each accepted character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            kp_reg    <= KP_NONE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            lower_reg <= 1'b0;
            line_reg  <= LINE_FIRST;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            kp_reg    <= kp_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            lower_reg <= lower_next;
            line_reg  <= line_next;
        end
    end

endmodule

`default_nettype wire

### sv/lpt_queue.sv
// ============================================================================
// lpt_queue: token queue
// A small register queue that takes up to two tokens per cycle and hands out
// one per cycle while the reader is ready, and signals room while two more fit.
// ============================================================================
`default_nettype none

module lpt_queue #(
    parameter int DATA_W = 61,
    parameter int DEPTH  = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_count,
    input  wire logic [DATA_W-1:0] push_data0,
    input  wire logic [DATA_W-1:0] push_data1,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [DATA_W-1:0] out_data
);

    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg,   fill_next;
    logic              pop;

    assign room      = (fill_reg <= ROOM_LIMIT);
    assign out_valid = (fill_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        fill_next   = fill_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Token storage; the second token goes into the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_data1;
        end
    end

endmodule

`default_nettype wire

### sv/logic_program_tokenizer_unit.sv
// ============================================================================
// logic_program_tokenizer_unit: streaming tokenizer for a logic language
// Takes one source character per word and delivers tokens with kind, numeral
// value, word length and line number.
// ============================================================================
// The unit accepts one character word every clock while its token queue has
// room for two tokens. A character is decided in the cycle it is accepted and
// its tokens can be taken from the next cycle on. The output delivers one token
// per clock while the receiver is ready; a character that closes a pending
// token and also gives one of its own (and the end mark after a pending token)
// puts two tokens into the queue, so a run of such characters is taken slower
// than one per clock, held back by the single read port of the four-entry queue.
// After the end-of-file token the scanner state and line start as after reset.
`default_nettype none

module logic_program_tokenizer_unit #(
    parameter int VALUE_BITS  = lpt_pkg::LPT_VALUE_BITS,
    parameter int LENGTH_BITS = lpt_pkg::LPT_LENGTH_BITS,
    parameter int LINE_BITS   = lpt_pkg::LPT_LINE_BITS
) (
    input wire logic    clk,
    input wire logic    rst_n,
    lpt_char_if.sink    char_in,
    lpt_token_if.source token_out
);

    localparam int TOK_W = 4 + VALUE_BITS + LENGTH_BITS + LINE_BITS + 1;

    logic             step;
    logic             room;
    logic [TOK_W-1:0] tok0;
    logic [TOK_W-1:0] tok1;
    logic [1:0]       tok_count;
    logic [1:0]       push_count;
    logic [TOK_W-1:0] head;

    assign char_in.ready = room;
    assign step          = char_in.valid & room;
    assign push_count    = step ? tok_count : 2'd0;

    lpt_scan #(
        .VALUE_BITS  (VALUE_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .char_code   (char_in.char_code),
        .end_of_text (char_in.end_of_text),
        .tok0        (tok0),
        .tok1        (tok1),
        .tok_count   (tok_count)
    );

    lpt_queue #(
        .DATA_W (TOK_W),
        .DEPTH  (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data0 (tok0),
        .push_data1 (tok1),
        .room       (room),
        .out_valid  (token_out.valid),
        .out_ready  (token_out.ready),
        .out_data   (head)
    );

    // Unpack the token at the head of the queue.
    assign token_out.token_kind  = head[TOK_W-1 -: 4];
    assign token_out.token_value = head[TOK_W-5 -: VALUE_BITS];
    assign token_out.word_length = head[LINE_BITS+LENGTH_BITS : LINE_BITS+1];
    assign token_out.line_number = head[LINE_BITS:1];
    assign token_out.last_token  = head[0];

endmodule

`default_nettype wire

### sv/lpt_checker.sv
// ============================================================================
// lpt_checker: port checks for the logic program tokenizer
// Watches the token channel and checks that each token word is held until it is
// taken, carries a nonzero line number and is consistent with its kind.
// ============================================================================
`default_nettype none

module lpt_checker #(
    parameter int VALUE_BITS  = lpt_pkg::LPT_VALUE_BITS,
    parameter int LENGTH_BITS = lpt_pkg::LPT_LENGTH_BITS,
    parameter int LINE_BITS   = lpt_pkg::LPT_LINE_BITS
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [3:0]             token_kind,
    input wire logic [VALUE_BITS-1:0]  token_value,
    input wire logic [LENGTH_BITS-1:0] word_length,
    input wire logic [LINE_BITS-1:0]   line_number,
    input wire logic                   last_token
);

    // A token word stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token word withdrawn before it was taken");

    // The closing flag marks exactly the end-of-file tokens.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_token == (token_kind == lpt_pkg::K_EOF)))
        else $error("closing flag does not match end-of-file kind");

    // Line numbers start at one and never wrap to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_number != '0))
        else $error("token carries line zero");

    // Only numerals carry a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind != lpt_pkg::K_NUMERAL) |-> (token_value == '0))
        else $error("value on a token that is not a numeral");

    // Only word classes carry a length, and a word is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((token_kind == lpt_pkg::K_LOWER || token_kind == lpt_pkg::K_UPPER)
                       == (word_length != '0)))
        else $error("word length does not match token kind");

endmodule

bind logic_program_tokenizer_unit lpt_checker #(
    .VALUE_BITS  (VALUE_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS)
) u_lpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (token_out.valid),
    .out_ready   (token_out.ready),
    .token_kind  (token_out.token_kind),
    .token_value (token_out.token_value),
    .word_length (token_out.word_length),
    .line_number (token_out.line_number),
    .last_token  (token_out.last_token)
);

`default_nettype wire
